>>> rtl/lfk_pkg.sv
// ----------------------------------------------------------------------------
// lfk_pkg
// Shared types, constants and the sine table generator for the leg
// forward kinematics block.
// ----------------------------------------------------------------------------
package lfk_pkg;

  localparam int ANGLE_W  = 9;    // input angle width
  localparam int RED_W    = 11;   // widest angle handed to the reducer
  localparam int TAB_IDX_W = 7;   // index into the 0..90 degree table
  localparam int LEN_W    = 12;   // link length register width
  localparam int POS_W    = 14;   // output position width
  localparam int REG_IDX_W = 3;   // configuration index width

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_HIP_OFFSET   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COXA_LENGTH  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FEMUR_LENGTH = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TIBIA_LENGTH = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BASE_HEIGHT  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FOOT_OFFSET  = 3'd5;

  // table entry select: quadrant-folded index plus sign
  typedef struct packed {
    logic [TAB_IDX_W-1:0] idx;
    logic                 neg;
  } trig_sel_t;

  // unsigned 64-bit restoring division, used at elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] num,
                                         input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // sin(d degrees) by a Taylor series in Q2.30, rounded to fb fraction bits.
  // Evaluated at elaboration only.
  function automatic logic [31:0] sin_entry(input int d, input int fb);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] dvs;
    logic [63:0] s;
    longint      sum;
    x    = udiv64(64'(d) * PI_Q30 + 64'd90, 64'd180);
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 12; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      dvs  = 64'((2 * n) * (2 * n + 1));
      term = udiv64(term, dvs);
      if ((n % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) sum = 0;
    if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
    s = (64'(sum) + (64'd1 << (29 - fb))) >> (30 - fb);
    return s[31:0];
  endfunction

endpackage

>>> rtl/lfk_angle_reduce.sv
// ----------------------------------------------------------------------------
// lfk_angle_reduce
// Folds an angle in degrees into a 0..90 table index and a sign, so that
// sin(angle) = sign * table[index].
// ----------------------------------------------------------------------------
module lfk_angle_reduce
  import lfk_pkg::*;
(
  input  logic signed [RED_W-1:0] angle,
  output trig_sel_t               sel
);

  logic signed [RED_W-1:0] r0;
  logic signed [RED_W-1:0] r1;
  logic signed [RED_W-1:0] r2;
  logic signed [RED_W-1:0] rr;

  // modulo 360 for the range -720..719
  always_comb begin
    r0 = (angle < 0) ? angle + 11'sd360 : angle;
    r1 = (r0 < 0) ? r0 + 11'sd360 : r0;
    r2 = (r1 >= 11'sd360) ? r1 - 11'sd360 : r1;
  end

  // quadrant fold
  always_comb begin
    priority if (r2 <= 11'sd90) begin
      rr      = r2;
      sel.neg = 1'b0;
    end else if (r2 <= 11'sd180) begin
      rr      = 11'sd180 - r2;
      sel.neg = 1'b0;
    end else if (r2 <= 11'sd270) begin
      rr      = r2 - 11'sd180;
      sel.neg = 1'b1;
    end else begin
      rr      = 11'sd360 - r2;
      sel.neg = 1'b1;
    end
    sel.idx = rr[TAB_IDX_W-1:0];
  end

endmodule

>>> rtl/leg_forward_kinematics.sv
// ----------------------------------------------------------------------------
// leg_forward_kinematics
// Foot position x, y, z of a three-joint leg from yaw, shoulder and knee
// angles, in fixed point with a constant sine table.
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  command   start, busy, yaw/shoulder/knee_angle      in (busy out)
//  result    done, pos_x, pos_y, pos_z                 out
//  config    wr_en, wr_index, wr_data                  in
//
// Six register stages: angle fold, table read, link multiplies, reach and
// z sums, yaw multiplies, x and y sums. One angle set is taken every
// cycle, so busy stays low. rst clears the valid bits and the configuration
// registers. The receiver cannot stall: done is a one-cycle strobe.
// ----------------------------------------------------------------------------
module leg_forward_kinematics
  import lfk_pkg::*;
#(
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [ANGLE_W-1:0]   yaw_angle,
  input  logic signed [ANGLE_W-1:0]   shoulder_angle,
  input  logic signed [ANGLE_W-1:0]   knee_angle,
  output logic                        done,
  output logic signed [POS_W-1:0]     pos_x,
  output logic signed [POS_W-1:0]     pos_y,
  output logic signed [POS_W-1:0]     pos_z,
  input  logic                        wr_en,
  input  logic [REG_IDX_W-1:0]        wr_index,
  input  logic [LEN_W-1:0]            wr_data
);

  localparam int FB  = TRIG_FRAC_BITS;
  localparam int TW  = FB + 2;           // signed trig value
  localparam int PW  = LEN_W + 1 + TW;   // link times trig
  localparam int W   = FB + 18;          // exact sums
  localparam int TRW = W - FB;           // truncated sum
  localparam logic [W-1:0] FRAC_MASK = {{(W-FB){1'b0}}, {FB{1'b1}}};

  // configuration registers
  logic [LEN_W-1:0] hip_offset, coxa_length, femur_length, tibia_length;
  logic [LEN_W-1:0] base_height, foot_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      hip_offset   <= '0;
      coxa_length  <= '0;
      femur_length <= '0;
      tibia_length <= '0;
      base_height  <= '0;
      foot_offset  <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_HIP_OFFSET:   hip_offset   <= wr_data;
        REG_COXA_LENGTH:  coxa_length  <= wr_data;
        REG_FEMUR_LENGTH: femur_length <= wr_data;
        REG_TIBIA_LENGTH: tibia_length <= wr_data;
        REG_BASE_HEIGHT:  base_height  <= wr_data;
        REG_FOOT_OFFSET:  foot_offset  <= wr_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // sine table, built at elaboration
  logic [FB:0] sin_tab [0:90];
  for (genvar gd = 0; gd <= 90; gd++) begin : g_tab
    localparam logic [31:0] ENTRY = sin_entry(gd, FB);
    assign sin_tab[gd] = ENTRY[FB:0];
  end

  // valid bits
  logic [5:0] vld;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else     vld <= {vld[4:0], start};
  end
  assign done = vld[5];

  // ---- stage 1: fold angles
  logic signed [RED_W-1:0] a_yaw_s, a_yaw_c, a_sh_s, a_sh_c, a_df_s, a_df_c;
  trig_sel_t sel_in [6];
  trig_sel_t sel1   [6];

  always_comb begin
    a_yaw_s = RED_W'(yaw_angle);
    a_yaw_c = RED_W'(yaw_angle) + 11'sd90;
    a_sh_s  = RED_W'(shoulder_angle);
    a_sh_c  = RED_W'(shoulder_angle) + 11'sd90;
    a_df_s  = RED_W'(knee_angle) - RED_W'(shoulder_angle);
    a_df_c  = a_df_s + 11'sd90;
  end

  lfk_angle_reduce u_red0 (.angle(a_yaw_s), .sel(sel_in[0]));
  lfk_angle_reduce u_red1 (.angle(a_yaw_c), .sel(sel_in[1]));
  lfk_angle_reduce u_red2 (.angle(a_sh_s),  .sel(sel_in[2]));
  lfk_angle_reduce u_red3 (.angle(a_sh_c),  .sel(sel_in[3]));
  lfk_angle_reduce u_red4 (.angle(a_df_s),  .sel(sel_in[4]));
  lfk_angle_reduce u_red5 (.angle(a_df_c),  .sel(sel_in[5]));

  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) sel1[i] <= sel_in[i];
  end

  // ---- stage 2: table read and sign
  logic signed [TW-1:0] trig2 [6];
  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      if (sel1[i].neg) trig2[i] <= -$signed({1'b0, sin_tab[sel1[i].idx]});
      else             trig2[i] <= $signed({1'b0, sin_tab[sel1[i].idx]});
    end
  end

  // ---- stage 3: link multiplies
  logic signed [PW-1:0] p_cs3, p_cd3, p_ss3, p_sd3;
  logic signed [TW-1:0] ysin3, ycos3;
  always_ff @(posedge clk) begin
    p_cs3 <= $signed({1'b0, femur_length}) * trig2[3];
    p_cd3 <= $signed({1'b0, tibia_length}) * trig2[5];
    p_ss3 <= $signed({1'b0, femur_length}) * trig2[2];
    p_sd3 <= $signed({1'b0, tibia_length}) * trig2[4];
    ysin3 <= trig2[0];
    ycos3 <= trig2[1];
  end

  // divide by 2^FB, toward zero
  function automatic logic signed [TRW-1:0] trunc_frac(input logic signed [W-1:0] v);
    logic signed [W-1:0] t;
    t = v + (v[W-1] ? FRAC_MASK : '0);
    return t[W-1:FB];
  endfunction

  function automatic logic signed [POS_W-1:0] sat14(input logic signed [TRW-1:0] v);
    if (v > TRW'(8191))       return 14'sd8191;
    else if (v < -TRW'(8192)) return -14'sd8192;
    else                      return v[POS_W-1:0];
  endfunction

  // ---- stage 4: reach and z
  logic signed [W-1:0]     reach_sum, z_sum;
  logic signed [LEN_W:0]   hdiff;
  logic signed [TRW-1:0]   reach4;
  logic signed [POS_W-1:0] z4, z5;
  logic signed [TW-1:0]    ysin4, ycos4;

  always_comb begin
    hdiff     = $signed({1'b0, base_height}) - $signed({1'b0, foot_offset});
    reach_sum = $signed({{(W-LEN_W-FB){1'b0}}, coxa_length, {FB{1'b0}}})
              + W'(p_cs3) + W'(p_cd3);
    z_sum     = $signed({{(W-LEN_W-1-FB){hdiff[LEN_W]}}, hdiff, {FB{1'b0}}})
              + W'(p_ss3) - W'(p_sd3);
  end

  always_ff @(posedge clk) begin
    reach4 <= trunc_frac(reach_sum);
    z4     <= sat14(trunc_frac(z_sum));
    ysin4  <= ysin3;
    ycos4  <= ycos3;
  end

  // ---- stage 5: yaw multiplies
  logic signed [W-1:0] px5, py5;
  always_ff @(posedge clk) begin
    px5 <= W'(reach4 * ycos4);
    py5 <= W'(reach4 * ysin4);
    z5  <= z4;
  end

  // ---- stage 6: x, y and output register
  logic signed [W-1:0] x_sum;
  assign x_sum = $signed({{(W-LEN_W-FB){1'b0}}, hip_offset, {FB{1'b0}}}) + px5;

  always_ff @(posedge clk) begin
    pos_x <= sat14(trunc_frac(x_sum));
    pos_y <= sat14(trunc_frac(py5));
    pos_z <= z5;
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks leg_forward_kinematics against a behavioral foot position predictor.
// A queue-fed driver issues angle sets with random gaps; a monitor compares
// every done strobe with the oldest predicted position, across several link
// configurations including all-zero and maximum link lengths.
// ----------------------------------------------------------------------------
module tb_top;
  import lfk_pkg::*;

  localparam int FRAC = 15;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;  // no register here
  localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] yaw;
    logic signed [ANGLE_W-1:0] shoulder;
    logic signed [ANGLE_W-1:0] knee;
  } angles_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } foot_pos_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic signed [ANGLE_W-1:0] yaw_angle, shoulder_angle, knee_angle;
  logic done;
  logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
  logic wr_en;
  logic [REG_IDX_W-1:0] wr_index;
  logic [LEN_W-1:0] wr_data;

  angles_t   angle_queue[$];
  foot_pos_t pos_queue[$];
  logic [LEN_W-1:0] link_cfg[0:5];
  int errors;
  int sent;
  int checked;
  int gap_left;
  bit steady;      // no idle cycles on the command side while set

  leg_forward_kinematics dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .yaw_angle(yaw_angle), .shoulder_angle(shoulder_angle), .knee_angle(knee_angle),
    .done(done), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sin(d) for 0..90 degrees: Q2.30 Taylor series, rounded to FRAC bits
  function automatic longint quarter_sine(int d);
    longint unsigned xr;
    longint unsigned t;
    longint acc;
    xr = (longint'(d) * PI_Q30 + 64'd90) / 64'd180;
    t = xr;
    acc = longint'(xr);
    for (int n = 1; n <= 12; n++) begin
      t = (t * xr) >> 30;
      t = (t * xr) >> 30;
      t = t / longint'((2 * n) * (2 * n + 1));
      acc = (n % 2 == 1) ? acc - longint'(t) : acc + longint'(t);
    end
    if (acc < 0) acc = 0;
    if (acc > (longint'(1) << 30)) acc = longint'(1) << 30;
    return (acc + (longint'(1) << (29 - FRAC))) >>> (30 - FRAC);
  endfunction

  function automatic longint sine_deg(int a);
    int r;
    r = a % 360;
    if (r < 0) r += 360;
    if (r <= 90) return quarter_sine(r);
    if (r <= 180) return quarter_sine(180 - r);
    if (r <= 270) return -quarter_sine(r - 180);
    return -quarter_sine(360 - r);
  endfunction

  function automatic logic signed [POS_W-1:0] clamp_pos(longint v);
    if (v > 8191) v = 8191;
    if (v < -8192) v = -8192;
    return v[POS_W-1:0];
  endfunction

  // foot position for one angle set; longint division truncates toward zero
  function automatic foot_pos_t foot_position(angles_t a);
    longint l0, l1, l2, l3, reach, sx, sy, sz, one;
    int yw, sh, kn;
    foot_pos_t p;
    one = longint'(1) << FRAC;
    yw = a.yaw;
    sh = a.shoulder;
    kn = a.knee;
    l0 = link_cfg[REG_HIP_OFFSET];
    l1 = link_cfg[REG_COXA_LENGTH];
    l2 = link_cfg[REG_FEMUR_LENGTH];
    l3 = link_cfg[REG_TIBIA_LENGTH];
    reach = (l1 * one + l2 * sine_deg(sh + 90) + l3 * sine_deg(kn - sh + 90)) / one;
    sx = (l0 * one + reach * sine_deg(yw + 90)) / one;
    sy = (reach * sine_deg(yw)) / one;
    sz = ((longint'(link_cfg[REG_BASE_HEIGHT]) - longint'(link_cfg[REG_FOOT_OFFSET])) * one
          + l2 * sine_deg(sh) - l3 * sine_deg(kn - sh)) / one;
    p.x = clamp_pos(sx);
    p.y = clamp_pos(sy);
    p.z = clamp_pos(sz);
    return p;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // driver: front of angle_queue is on the ports while start is high
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        pos_queue.push_back(foot_position(angle_queue.pop_front()));
        sent++;
        gap_left = pick_gap();
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (angle_queue.size() > 0) begin
        start <= 1'b1;
        yaw_angle <= angle_queue[0].yaw;
        shoulder_angle <= angle_queue[0].shoulder;
        knee_angle <= angle_queue[0].knee;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: each done strobe against the oldest prediction
  always @(posedge clk) begin
    foot_pos_t want;
    if (!rst && done) begin
      if (pos_queue.size() == 0) begin
        report_mismatch("unexpected transaction, pos_x", pos_x, 0);
      end else begin
        want = pos_queue.pop_front();
        checked++;
        if (pos_x !== want.x) report_mismatch("pos_x", pos_x, want.x);
        if (pos_y !== want.y) report_mismatch("pos_y", pos_y, want.y);
        if (pos_z !== want.z) report_mismatch("pos_z", pos_z, want.z);
      end
    end
  end

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [LEN_W-1:0] val);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    if (idx <= REG_FOOT_OFFSET) link_cfg[idx] = val;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic set_links(int h, int c, int f, int t, int b, int o);
    write_reg(REG_HIP_OFFSET, LEN_W'(h));
    write_reg(REG_COXA_LENGTH, LEN_W'(c));
    write_reg(REG_FEMUR_LENGTH, LEN_W'(f));
    write_reg(REG_TIBIA_LENGTH, LEN_W'(t));
    write_reg(REG_BASE_HEIGHT, LEN_W'(b));
    write_reg(REG_FOOT_OFFSET, LEN_W'(o));
  endtask

  task automatic queue_angles(int yw, int sh, int kn);
    angles_t a;
    a.yaw = ANGLE_W'(yw);
    a.shoulder = ANGLE_W'(sh);
    a.knee = ANGLE_W'(kn);
    @(negedge clk);
    angle_queue.push_back(a);
  endtask

  // wait until both queues are empty and start is low, then let the pipe settle
  task automatic drain();
    while (angle_queue.size() > 0 || start || pos_queue.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic random_angles(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 8)
        queue_angles($urandom_range(0, 360) - 180, $urandom_range(0, 360) - 180,
                     $urandom_range(0, 360) - 180);
      else
        queue_angles($urandom_range(0, 511) - 256, $urandom_range(0, 511) - 256,
                     $urandom_range(0, 511) - 256);
      if (i % 100 == 0) steady = ($urandom_range(0, 3) == 0);
    end
  endtask

  function automatic int rlen();
    return $urandom_range(0, 3) == 0 ? $urandom_range(3000, 4095) : $urandom_range(0, 1500);
  endfunction

  // stimulus
  initial begin
    int corner[] = '{-256, 255, -180, 180, 0, 90, -90, 45, 135, -135, 1, -1};
    errors = 0;
    sent = 0;
    checked = 0;
    steady = 1'b0;
    for (int i = 0; i < 6; i++) link_cfg[i] = '0;
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    start = 1'b0;
    yaw_angle = '0;
    shoulder_angle = '0;
    knee_angle = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset values: all links zero
    queue_angles(30, 60, 90);
    queue_angles(-256, 255, -256);
    drain();

    // maximum lengths, zero foot offset: saturation, and directed angle corners
    set_links(4095, 4095, 4095, 4095, 4095, 0);
    foreach (corner[i]) queue_angles(corner[i], corner[(i + 3) % 12], corner[(i + 7) % 12]);
    drain();

    // negative z extreme; writes to unused indexes must be ignored
    set_links(0, 4095, 4095, 4095, 0, 4095);
    write_reg(REG_SPARE_LO, 12'hFFF);
    write_reg(REG_SPARE_HI, 12'h5A5);
    queue_angles(0, -90, 90);
    queue_angles(180, 90, -90);
    queue_angles(-180, 180, 0);
    queue_angles(255, -256, 255);
    queue_angles(90, 0, 180);
    queue_angles(-90, 45, -45);
    queue_angles(0, 0, 0);
    random_angles(300);
    drain();

    // random settings, small and mixed
    for (int ph = 0; ph < 5; ph++) begin
      set_links(rlen(), rlen(), rlen(), rlen(), rlen(), rlen());
      random_angles(300);
      drain();
    end

    $display("Sent %0d angle transactions, checked %0d positions", sent, checked);
    $display("Link settings: reset, all-max, z-min and five random sets");
    if (errors == 0 && pos_queue.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("Timeout with %0d positions pending", pos_queue.size());
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
